### sv/smsd_pkg.sv
package smsd_pkg;

   // Default sizes for the top level parameters
   localparam int DEF_MAX_WINDOW = 256;
   localparam int DEF_SAMPLE_BITS = 16;

   // Fixed field widths
   localparam int CSR_LEN_BITS = 9;
   localparam logic [CSR_LEN_BITS-1:0] CSR_LEN_RESET = 9'd5;
   localparam int COUNT_BITS = 32;
   // alert (1) + alert_count (32), padded to whole bytes
   localparam int RSP_DATA_BITS = 40;

   // Controls broadcast to every cell of the sorted chain
   typedef struct packed {
      logic clear;          // drop the whole window
      logic update;         // move one sample through the chain
      logic full;           // remove the oldest value while inserting
      logic sample_ge_old;  // new sample lands right of the removed one
   } cell_ctrl_type;

endpackage

### sv/sliding_median_spike_detector_unit.sv
// Flow: an accepted sample goes through the cell chain update (ST_UPDATE) and the two-level
//    median select (ST_MED, ST_SETTLE) before its result beat is raised on rsp_. A new sample is
//    taken only in ST_IDLE or ST_SETTLE; a stalled result port holds the unit in ST_SETTLE.
// Reset (synchronous, active high): window emptied, alert count zeroed, window length set to 5.
//    The arrival ring holds no reset; each entry is written before it is read.
module sliding_median_spike_detector_unit #(
   parameter int MAX_WINDOW = smsd_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = smsd_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // sample input beats
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  req_tdata,   // [SAMPLE_BITS-1:0] sample
   // result beats
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [smsd_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,   // [0] alert, [32:1] alert_count
   output logic                                      rsp_tuser,   // [0] window_full
   // window length register
   input  logic                                      csr_wr_en,
   input  logic [smsd_pkg::CSR_LEN_BITS-1:0]         csr_wr_data
);

   import smsd_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_WINDOW);
   localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS = (LEN_BITS > CSR_LEN_BITS) ? LEN_BITS : CSR_LEN_BITS;
   localparam int PAD_BITS = RSP_DATA_BITS - 1 - COUNT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MED,
      ST_SETTLE
   } state_type;

   state_type               state_ff, state_in;
   logic [CSR_LEN_BITS-1:0] csr_len_ff, csr_len_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [LEN_BITS-1:0]     fill_ff, fill_in;
   logic [IDX_BITS-1:0]     ptr_ff, ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    pend_alert_ff, pend_alert_in;
   logic                    pend_full_ff, pend_full_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic                    rsp_alert_ff, rsp_alert_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;

   logic [CMP_BITS-1:0]     len_ext;
   logic [LEN_BITS-1:0]     eff_len;
   logic [LEN_BITS-1:0]     eff_len_m1;
   logic [IDX_BITS-1:0]     lo_idx;
   logic [IDX_BITS-1:0]     hi_idx;
   logic [LEN_BITS-1:0]     ptr_p1;
   logic                    full;
   logic                    slot_free;
   logic                    accept;
   logic                    alert_now;
   logic [SAMPLE_BITS:0]    twice_med;
   logic [SAMPLE_BITS-1:0]  lo_val;
   logic [SAMPLE_BITS-1:0]  hi_val;

   logic                    ram_wr_en;
   logic [IDX_BITS-1:0]     ram_wr_addr;
   logic [SAMPLE_BITS-1:0]  old_val;

   cell_ctrl_type                          cell_ctrl;
   logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] cell_val;
   logic [MAX_WINDOW-1:0]                  cell_valid;
   logic [MAX_WINDOW-1:0]                  cell_le;
   logic [MAX_WINDOW-1:0]                  cell_ge;

   // Effective window: zero counts as one, anything past the chain length saturates
   always_comb begin
      len_ext = CMP_BITS'(csr_len_ff);
      if (len_ext == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (len_ext > CMP_BITS'(MAX_WINDOW)) begin
         eff_len = LEN_BITS'(MAX_WINDOW);
      end else begin
         eff_len = LEN_BITS'(len_ext);
      end
   end

   // Middle positions of the sorted chain; both are the same cell for an odd window,
   // so twice the median is always the sum of the two
   assign eff_len_m1 = eff_len - LEN_BITS'(1);
   assign lo_idx = IDX_BITS'(eff_len_m1 >> 1);
   assign hi_idx = IDX_BITS'(eff_len >> 1);

   assign full = (fill_ff >= eff_len);
   assign ptr_p1 = LEN_BITS'(ptr_ff) + LEN_BITS'(1);
   assign twice_med = {1'b0, lo_val} + {1'b0, hi_val};
   assign alert_now = full && ({1'b0, sample_ff} >= twice_med);

   // Output slot frees up when empty or when the waiting beat is taken this cycle
   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   // Take a new sample once the median of the current window has settled
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_SETTLE) && slot_free);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      csr_len_in = csr_len_ff;
      sample_in = sample_ff;
      fill_in = fill_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      pend_alert_in = pend_alert_ff;
      pend_full_in = pend_full_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_alert_in = rsp_alert_ff;
      rsp_full_in = rsp_full_ff;
      rsp_count_in = rsp_count_ff;

      // Drop the result beat once it is taken
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Check against the window before this sample, then advance ring bookkeeping
            pend_alert_in = alert_now;
            pend_full_in = full;
            if (alert_now && (count_ff != '1)) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
            if (full) begin
               ptr_in = (ptr_p1 >= eff_len) ? '0 : IDX_BITS'(ptr_p1);
               fill_in = eff_len;
            end else begin
               ptr_in = '0;
               fill_in = fill_ff + LEN_BITS'(1);
            end
            state_in = ST_MED;
         end
         ST_MED: begin
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            // Hold here until the previous result beat has left
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_alert_in = pend_alert_ff;
               rsp_full_in = pend_full_ff;
               rsp_count_in = count_ff;
               if (accept) begin
                  sample_in = req_tdata[SAMPLE_BITS-1:0];
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write empties the window; the alert count is kept
      if (csr_wr_en) begin
         csr_len_in = csr_wr_data;
         fill_in = '0;
         ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csr_len_ff <= CSR_LEN_RESET;
         fill_ff <= '0;
         ptr_ff <= '0;
         count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         csr_len_ff <= csr_len_in;
         fill_ff <= fill_in;
         ptr_ff <= ptr_in;
         count_ff <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      sample_ff <= sample_in;
      pend_alert_ff <= pend_alert_in;
      pend_full_ff <= pend_full_in;
      rsp_alert_ff <= rsp_alert_in;
      rsp_full_ff <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {PAD_BITS'(0), rsp_count_ff, rsp_alert_ff};
   assign rsp_tuser = rsp_full_ff;

   // Arrival ring: the read port always looks at the oldest entry, so the value to
   // remove is ready by the time the next sample reaches the chain
   assign ram_wr_en = (state_ff == ST_UPDATE);
   assign ram_wr_addr = full ? ptr_ff : fill_ff[IDX_BITS-1:0];

   smsd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (sample_ff),
      .rd_addr (ptr_ff),
      .rd_data (old_val)
   );

   // Sorted window: one value per cell, ascending left to right. Equal values keep
   // arrival order, so the leftmost copy of the oldest value is the one to drop.
   assign cell_ctrl.clear = csr_wr_en;
   assign cell_ctrl.update = (state_ff == ST_UPDATE);
   assign cell_ctrl.full = full;
   assign cell_ctrl.sample_ge_old = (sample_ff >= old_val);

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] left_val;
      logic                   left_valid;
      logic                   left_le;
      logic                   left_ge;
      logic [SAMPLE_BITS-1:0] right_val;
      logic                   right_le;

      // The left edge acts as a filled cell below everything
      if (i == 0) begin : g_left_edge
         assign left_val = '0;
         assign left_valid = 1'b1;
         assign left_le = 1'b1;
         assign left_ge = 1'b0;
      end else begin : g_left
         assign left_val = cell_val[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_le = cell_le[i-1];
         assign left_ge = cell_ge[i-1];
      end

      // The right edge acts as an empty cell
      if (i == MAX_WINDOW - 1) begin : g_right_edge
         assign right_val = '0;
         assign right_le = 1'b0;
      end else begin : g_right
         assign right_val = cell_val[i+1];
         assign right_le = cell_le[i+1];
      end

      smsd_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .sample     (sample_ff),
         .old_val    (old_val),
         .left_val   (left_val),
         .left_valid (left_valid),
         .left_le    (left_le),
         .left_ge    (left_ge),
         .right_val  (right_val),
         .right_le   (right_le),
         .val        (cell_val[i]),
         .valid      (cell_valid[i]),
         .le         (cell_le[i]),
         .ge         (cell_ge[i])
      );
   end

   smsd_median_sel #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_median (
      .clock     (clock),
      .cell_vals (cell_val),
      .lo_idx    (lo_idx),
      .hi_idx    (hi_idx),
      .lo_val    (lo_val),
      .hi_val    (hi_val)
   );

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_len)
      else $error("fill level beyond window length");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      LEN_BITS'(ptr_ff) < eff_len)
      else $error("oldest pointer outside window");

   a_chain_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(fill_ff))
      else $error("occupied cells disagree with fill level");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_SETTLE)
      else $error("result beat raised outside settle state");

   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff >= $past(count_ff))
      else $error("alert count went down");
`endif

endmodule

### sv/smsd_ram.sv
module smsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/smsd_cell.sv
module smsd_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  smsd_pkg::cell_ctrl_type  ctrl,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [SAMPLE_BITS-1:0]   old_val,
   input  logic [SAMPLE_BITS-1:0]   left_val,
   input  logic                     left_valid,
   input  logic                     left_le,
   input  logic                     left_ge,
   input  logic [SAMPLE_BITS-1:0]   right_val,
   input  logic                     right_le,
   output logic [SAMPLE_BITS-1:0]   val,
   output logic                     valid,
   output logic                     le,
   output logic                     ge
);

   import smsd_pkg::*;

   logic [SAMPLE_BITS-1:0] val_ff;
   logic [SAMPLE_BITS-1:0] val_in;
   logic                   valid_ff;
   logic                   valid_in;

   // An empty cell counts as larger than any sample
   assign le = valid_ff && (val_ff <= sample);
   assign ge = !valid_ff || (val_ff >= old_val);

   always_comb begin
      val_in = val_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.update) begin
         if (!ctrl.full) begin
            // insert only: larger values step right
            valid_in = valid_ff | left_valid;
            if (!le) begin
               val_in = left_le ? sample : left_val;
            end
         end else if (!ctrl.sample_ge_old) begin
            // insert left of the removed value: gap closes from the left
            if (!le) begin
               if (left_le) begin
                  val_in = sample;
               end else if (!left_ge) begin
                  val_in = left_val;
               end
            end
         end else begin
            // insert right of the removed value: gap closes from the right
            if (ge) begin
               if (right_le) begin
                  val_in = right_val;
               end else if (!(left_ge && !le)) begin
                  val_in = sample;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign valid = valid_ff;

endmodule

### sv/smsd_median_sel.sv
module smsd_median_sel #(
   parameter int MAX_WINDOW = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                     clock,
   input  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]   cell_vals,
   input  logic [$clog2(MAX_WINDOW)-1:0]            lo_idx,
   input  logic [$clog2(MAX_WINDOW)-1:0]            hi_idx,
   output logic [SAMPLE_BITS-1:0]                   lo_val,
   output logic [SAMPLE_BITS-1:0]                   hi_val
);

   import smsd_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_WINDOW);
   localparam int SEL_BITS = (IDX_BITS < 2) ? 2 : IDX_BITS;
   localparam int LO_BITS = SEL_BITS / 2;
   localparam int HI_BITS = SEL_BITS - LO_BITS;
   localparam int GROUPS = 2 ** HI_BITS;
   localparam int PAD_DEPTH = 2 ** SEL_BITS;

   logic [PAD_DEPTH-1:0][SAMPLE_BITS-1:0] padded;
   logic [SEL_BITS-1:0]                   lo_sel;
   logic [SEL_BITS-1:0]                   hi_sel;
   logic [GROUPS-1:0][SAMPLE_BITS-1:0]    grp_lo_in;
   logic [GROUPS-1:0][SAMPLE_BITS-1:0]    grp_hi_in;
   logic [GROUPS-1:0][SAMPLE_BITS-1:0]    grp_lo_ff;
   logic [GROUPS-1:0][SAMPLE_BITS-1:0]    grp_hi_ff;
   logic [HI_BITS-1:0]                    lo_grp_ff;
   logic [HI_BITS-1:0]                    hi_grp_ff;
   logic [SAMPLE_BITS-1:0]                lo_val_ff;
   logic [SAMPLE_BITS-1:0]                hi_val_ff;

   assign lo_sel = SEL_BITS'(lo_idx);
   assign hi_sel = SEL_BITS'(hi_idx);

   always_comb begin
      padded = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         padded[i] = cell_vals[i];
      end
   end

   // First level: pick the entry inside every group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_lo_in[g] = padded[{HI_BITS'(g), lo_sel[LO_BITS-1:0]}];
         grp_hi_in[g] = padded[{HI_BITS'(g), hi_sel[LO_BITS-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      grp_lo_ff <= grp_lo_in;
      grp_hi_ff <= grp_hi_in;
      lo_grp_ff <= lo_sel[SEL_BITS-1:LO_BITS];
      hi_grp_ff <= hi_sel[SEL_BITS-1:LO_BITS];
      // Second level: pick the group
      lo_val_ff <= grp_lo_ff[lo_grp_ff];
      hi_val_ff <= grp_hi_ff[hi_grp_ff];
   end

   assign lo_val = lo_val_ff;
   assign hi_val = hi_val_ff;

endmodule
